// ===== hw/rtl/srp_pkg.sv =====
`default_nettype none
package srp_pkg;

   localparam int MAX_RECTS   = 64;
   localparam int IDX_BITS    = $clog2(MAX_RECTS);
   localparam int CNT_BITS    = $clog2(MAX_RECTS + 1);
   localparam int SIZE_BITS   = 10;
   localparam int COORD_BITS  = 16;
   localparam int DIM_BITS    = COORD_BITS + 1;
   localparam int AREA_BITS   = 2 * SIZE_BITS + IDX_BITS;
   localparam int WL_BITS     = 5;
   localparam int WL_LIMIT    = 31;
   localparam int YOFF_BITS   = SIZE_BITS + 1;
   // each nested sub-shelf is at most half as tall as its parent
   localparam int STACK_DEPTH = SIZE_BITS + 1;
   localparam int DEPTH_BITS  = $clog2(STACK_DEPTH + 1);

   typedef struct packed {
      logic [SIZE_BITS-1:0] rect_width;
      logic [SIZE_BITS-1:0] rect_height;
      logic                 last_rect;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]   rect_index;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [SIZE_BITS-1:0]  padded_height;
      logic [DIM_BITS-1:0]   atlas_width;
      logic [DIM_BITS-1:0]   atlas_height;
      logic                  overflow;
      logic                  last_result;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] w;
      logic [SIZE_BITS-1:0] h;
   } size_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]  idx;
      logic [SIZE_BITS-1:0] w;
      logic [SIZE_BITS-1:0] h;
   } sort_entry_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [SIZE_BITS-1:0]  h;
   } place_type;

   // one open shelf fill: its right-hand gap and sub-shelf progress
   typedef struct packed {
      logic [DIM_BITS-1:0]  tail;
      logic [DIM_BITS-1:0]  y;
      logic [SIZE_BITS-1:0] orig;
      logic [SIZE_BITS-1:0] hcur;
      logic [YOFF_BITS-1:0] yoff;
      logic [CNT_BITS-1:0]  start;
   } frame_type;

   typedef struct packed {
      logic      push;
      logic      pop;
      logic      upd;
      frame_type frame;
   } stk_cmd_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_WL_AREA,
      ST_WL_WIDE,
      ST_SORT_RDI,
      ST_SORT_GETI,
      ST_SORT_RDJ,
      ST_SORT_EVJ,
      ST_SORT_WR,
      ST_PASS_INIT,
      ST_TOP_RD,
      ST_TOP_EV,
      ST_BS_RD,
      ST_BS_EV,
      ST_BS_FAIL,
      ST_FS_RD,
      ST_FS_EV,
      ST_FL_POST,
      ST_FL_HALVE,
      ST_RET_T,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_HOLD
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/srp_frame_stack.sv =====
`default_nettype none
module srp_frame_stack import srp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  stk_cmd_type           cmd,
   output frame_type             top_frame,
   output logic [DEPTH_BITS-1:0] depth
);

   frame_type             stk_ff [STACK_DEPTH];
   logic [DEPTH_BITS-1:0] sp_ff;
   logic [DEPTH_BITS-1:0] sp_in;
   logic [DEPTH_BITS-1:0] top_idx;

   assign top_idx = (sp_ff == '0) ? '0 : sp_ff - DEPTH_BITS'(1);

   always_comb begin
      sp_in = sp_ff;
      if (cmd.push) begin
         sp_in = sp_ff + DEPTH_BITS'(1);
      end else if (cmd.pop) begin
         sp_in = sp_ff - DEPTH_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stk_ff[sp_ff] <= cmd.frame;
      end else if (cmd.upd) begin
         stk_ff[top_idx] <= cmd.frame;
      end
   end

   assign top_frame = stk_ff[top_idx];
   assign depth     = sp_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/shelf_rect_packer.sv =====
`default_nettype none
// Channel  Ports                        Dir  Moves
// req      req_valid/req_stall/req_data in   one rectangle size item, last_rect ends set
// rsp      rsp_valid/rsp_stall/rsp_data out  one placement item per stored rectangle
//
// Loading takes one item per cycle. After the last item the block stalls req and runs:
// a start width search, a rank sort over the size memory (each compare waits on the single
// memory read port), then one or more packing passes, repeated once per width doubling.
// Results then go out one at a time, each held until rsp_stall drops.
// Reset is synchronous and leaves the block empty and ready to load.
module shelf_rect_packer import srp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;

   // set statistics
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [AREA_BITS-1:0] area_ff, area_in;
   logic [SIZE_BITS-1:0] widest_ff, widest_in;
   logic                 dropped_ff, dropped_in;
   logic                 ovf_ff, ovf_in;
   logic [WL_BITS-1:0]   wl_ff, wl_in;

   // sort counters
   logic [CNT_BITS-1:0]  si_ff, si_in;
   logic [CNT_BITS-1:0]  sj_ff, sj_in;
   logic [IDX_BITS-1:0]  rank_ff, rank_in;
   size_type             cur_ff, cur_in;

   // packing pass
   logic [CNT_BITS-1:0]  ti_ff, ti_in;
   logic [DIM_BITS-1:0]  ty_ff, ty_in;
   logic [SIZE_BITS-1:0] toph_ff, toph_in;
   logic [CNT_BITS-1:0]  scan_ff, scan_in;
   logic [DIM_BITS-1:0]  bx_ff, bx_in;
   logic [DIM_BITS-1:0]  by_ff, by_in;
   logic [SIZE_BITS-1:0] bh_ff, bh_in;
   logic [MAX_RECTS-1:0] taken_ff, taken_in;
   logic [MAX_RECTS-1:0] pvalid_ff, pvalid_in;

   // result side
   logic [CNT_BITS-1:0]  oi_ff, oi_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // memories
   size_type             size_mem [MAX_RECTS];
   size_type             size_rd_ff;
   sort_entry_type       sort_mem [MAX_RECTS];
   sort_entry_type       sort_rd_ff;
   place_type            place_mem [MAX_RECTS];
   place_type            place_rd_ff;

   logic                 size_we;
   logic [IDX_BITS-1:0]  size_raddr;
   logic                 sort_we;
   logic [IDX_BITS-1:0]  sort_raddr;
   logic                 place_we;
   place_type            place_wdata;

   // frame stack
   stk_cmd_type           stk_cmd;
   frame_type             ftop;
   logic [DEPTH_BITS-1:0] stk_depth;

   srp_frame_stack u_stack (
      .clock     (clock),
      .reset     (reset),
      .cmd       (stk_cmd),
      .top_frame (ftop),
      .depth     (stk_depth)
   );

   // shared decisions
   logic                 acc;
   logic                 has_room;
   logic [DIM_BITS-1:0]  cw;
   logic [WL_BITS:0]     wl2;
   logic [AREA_BITS:0]   apow;
   logic [SIZE_BITS:0]   wpow;
   logic                 area_grow;
   logic                 wide_grow;
   logic                 sort_before;
   logic                 sort_jlast;
   logic                 sort_ilast;
   logic                 ti_end;
   logic                 ti_taken;
   logic                 scan_end;
   logic                 scan_taken;
   logic                 need_wider;
   logic                 bs_tall;
   logic                 bs_short;
   logic                 bs_wide;
   logic [DIM_BITS:0]    bs_end;
   logic [DIM_BITS:0]    fs_end;
   logic                 fs_short;
   logic                 fs_fit;
   logic                 fs_full;
   logic [SIZE_BITS-1:0] halve_h;
   logic [YOFF_BITS-1:0] ret_nyoff;
   logic                 ret_over;
   logic                 out_last;

   assign acc       = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_LOAD);
   assign has_room  = cnt_ff < CNT_BITS'(MAX_RECTS);
   assign cw        = DIM_BITS'(1) << wl_ff;

   assign wl2       = {wl_ff, 1'b0};
   assign apow      = (AREA_BITS + 1)'(1) << wl2;
   assign wpow      = (SIZE_BITS + 1)'(1) << wl_ff;
   assign area_grow = (wl_ff < WL_BITS'(WL_LIMIT)) && (wl2 <= (WL_BITS + 1)'(AREA_BITS))
                      && (apow < {1'b0, area_ff});
   assign wide_grow = (wl_ff < WL_BITS'(WL_LIMIT)) && (wl_ff <= WL_BITS'(SIZE_BITS))
                      && (wpow < {1'b0, widest_ff});

   // j goes before i: taller, then wider, then earlier load
   assign sort_before = (size_rd_ff.h > cur_ff.h)
                        || ((size_rd_ff.h == cur_ff.h)
                            && ((size_rd_ff.w > cur_ff.w)
                                || ((size_rd_ff.w == cur_ff.w) && (sj_ff < si_ff))));
   assign sort_jlast  = (sj_ff + CNT_BITS'(1)) == cnt_ff;
   assign sort_ilast  = (si_ff + CNT_BITS'(1)) == cnt_ff;

   assign ti_end     = (ti_ff == cnt_ff);
   assign ti_taken   = taken_ff[ti_ff[IDX_BITS-1:0]];
   assign scan_end   = (scan_ff == cnt_ff);
   assign scan_taken = taken_ff[scan_ff[IDX_BITS-1:0]];
   assign need_wider = ty_ff > cw;

   assign bs_tall  = sort_rd_ff.h > bh_ff;
   assign bs_short = {sort_rd_ff.h, 1'b0} <= {1'b0, bh_ff};
   assign bs_end   = {1'b0, bx_ff} + (DIM_BITS + 1)'(sort_rd_ff.w);
   assign bs_wide  = bs_end > {1'b0, cw};

   assign fs_end   = {1'b0, ftop.tail} + (DIM_BITS + 1)'(sort_rd_ff.w);
   assign fs_short = {sort_rd_ff.h, 1'b0} <= {1'b0, ftop.orig};
   assign fs_fit   = fs_end <= {1'b0, cw};
   assign fs_full  = fs_end == {1'b0, cw};

   assign halve_h   = ftop.hcur >> 1;
   assign ret_nyoff = ftop.yoff + YOFF_BITS'(ftop.hcur);
   assign ret_over  = ({1'b0, ret_nyoff} + (YOFF_BITS + 1)'(ftop.hcur))
                      > (YOFF_BITS + 1)'(ftop.orig);

   assign out_last  = oi_ff == (cnt_ff - CNT_BITS'(1));

   assign size_raddr = (state_ff == ST_SORT_RDI) ? si_ff[IDX_BITS-1:0] : sj_ff[IDX_BITS-1:0];
   assign sort_raddr = (state_ff == ST_TOP_RD) ? ti_ff[IDX_BITS-1:0] : scan_ff[IDX_BITS-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (acc && req_data.last_rect) state_in = ST_WL_AREA;
         end
         ST_WL_AREA: begin
            if (!area_grow) state_in = ST_WL_WIDE;
         end
         ST_WL_WIDE: begin
            if (!wide_grow) state_in = ST_SORT_RDI;
         end
         ST_SORT_RDI:  state_in = ST_SORT_GETI;
         ST_SORT_GETI: state_in = ST_SORT_RDJ;
         ST_SORT_RDJ:  state_in = ST_SORT_EVJ;
         ST_SORT_EVJ: begin
            state_in = sort_jlast ? ST_SORT_WR : ST_SORT_RDJ;
         end
         ST_SORT_WR: begin
            state_in = sort_ilast ? ST_PASS_INIT : ST_SORT_RDI;
         end
         ST_PASS_INIT: state_in = ST_TOP_RD;
         ST_TOP_RD: begin
            if (ti_end) begin
               state_in = (need_wider && (wl_ff < WL_BITS'(COORD_BITS))) ? ST_PASS_INIT
                                                                        : ST_OUT_RD;
            end else if (!ti_taken) begin
               state_in = ST_TOP_EV;
            end
         end
         ST_TOP_EV: state_in = ST_BS_RD;
         ST_BS_RD: begin
            if (scan_end) begin
               state_in = ST_BS_FAIL;
            end else if (!scan_taken) begin
               state_in = ST_BS_EV;
            end
         end
         ST_BS_EV: begin
            if (bs_tall) begin
               state_in = ST_BS_RD;
            end else if (bs_short) begin
               state_in = ST_BS_FAIL;
            end else if (bs_wide) begin
               state_in = ST_BS_RD;
            end else begin
               state_in = ST_FS_RD;
            end
         end
         ST_BS_FAIL: begin
            state_in = (stk_depth == '0) ? ST_TOP_RD : ST_FL_HALVE;
         end
         ST_FS_RD: begin
            if (scan_end) begin
               state_in = ST_FL_POST;
            end else if (!scan_taken) begin
               state_in = ST_FS_EV;
            end
         end
         ST_FS_EV: begin
            if (fs_short) begin
               state_in = ST_FL_POST;
            end else if (fs_fit && fs_full) begin
               state_in = ST_RET_T;
            end else begin
               state_in = ST_FS_RD;
            end
         end
         ST_FL_POST: begin
            state_in = (ftop.orig == SIZE_BITS'(1)) ? ST_RET_T : ST_FL_HALVE;
         end
         ST_FL_HALVE: begin
            state_in = (halve_h == '0) ? ST_RET_T : ST_BS_RD;
         end
         ST_RET_T: begin
            if (stk_depth == '0) begin
               state_in = ST_TOP_RD;
            end else if (!ret_over) begin
               state_in = ST_BS_RD;
            end
         end
         ST_OUT_RD: state_in = ST_OUT_LD;
         ST_OUT_LD: state_in = ST_OUT_HOLD;
         ST_OUT_HOLD: begin
            if (!rsp_stall) state_in = out_last ? ST_LOAD : ST_OUT_RD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // datapath
   always_comb begin
      cnt_in       = cnt_ff;
      area_in      = area_ff;
      widest_in    = widest_ff;
      dropped_in   = dropped_ff;
      ovf_in       = ovf_ff;
      wl_in        = wl_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      rank_in      = rank_ff;
      cur_in       = cur_ff;
      ti_in        = ti_ff;
      ty_in        = ty_ff;
      toph_in      = toph_ff;
      scan_in      = scan_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      bh_in        = bh_ff;
      taken_in     = taken_ff;
      pvalid_in    = pvalid_ff;
      oi_in        = oi_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      size_we      = 1'b0;
      sort_we      = 1'b0;
      place_we     = 1'b0;
      place_wdata  = '0;
      stk_cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            if (acc) begin
               if (has_room) begin
                  size_we = 1'b1;
                  cnt_in  = cnt_ff + CNT_BITS'(1);
                  area_in = area_ff + AREA_BITS'(req_data.rect_width)
                                      * AREA_BITS'(req_data.rect_height);
                  if (req_data.rect_width > widest_ff) widest_in = req_data.rect_width;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.last_rect) begin
                  wl_in  = '0;
                  ovf_in = dropped_ff || !has_room;
               end
            end
         end
         ST_WL_AREA: begin
            if (area_grow) wl_in = wl_ff + WL_BITS'(1);
         end
         ST_WL_WIDE: begin
            si_in = '0;
            if (wide_grow) begin
               wl_in = wl_ff + WL_BITS'(1);
            end else if (wl_ff > WL_BITS'(COORD_BITS)) begin
               wl_in  = WL_BITS'(COORD_BITS);
               ovf_in = 1'b1;
            end
         end
         ST_SORT_GETI: begin
            cur_in  = size_rd_ff;
            sj_in   = '0;
            rank_in = '0;
         end
         ST_SORT_EVJ: begin
            if (sort_before) rank_in = rank_ff + IDX_BITS'(1);
            sj_in = sj_ff + CNT_BITS'(1);
         end
         ST_SORT_WR: begin
            sort_we = 1'b1;
            si_in   = si_ff + CNT_BITS'(1);
         end
         ST_PASS_INIT: begin
            taken_in  = '0;
            pvalid_in = '0;
            ti_in     = '0;
            ty_in     = '0;
         end
         ST_TOP_RD: begin
            if (ti_end) begin
               oi_in = '0;
               if (need_wider) begin
                  if (wl_ff < WL_BITS'(COORD_BITS)) begin
                     wl_in = wl_ff + WL_BITS'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end else if (ti_taken) begin
               ti_in = ti_ff + CNT_BITS'(1);
            end
         end
         ST_TOP_EV: begin
            toph_in = sort_rd_ff.h;
            bx_in   = '0;
            by_in   = ty_ff;
            bh_in   = sort_rd_ff.h;
            scan_in = ti_ff;
         end
         ST_BS_RD: begin
            if (!scan_end && scan_taken) scan_in = scan_ff + CNT_BITS'(1);
         end
         ST_BS_EV: begin
            if (bs_tall || (!bs_short && bs_wide)) begin
               scan_in = scan_ff + CNT_BITS'(1);
            end else if (!bs_short) begin
               // shelf head: place at shelf height of its own, open a fill frame
               // x at the full atlas width clips to the top coordinate
               place_we    = 1'b1;
               place_wdata = '{x: (bx_ff[COORD_BITS] ? {COORD_BITS{1'b1}}
                                                     : bx_ff[COORD_BITS-1:0]),
                               y: by_ff[COORD_BITS-1:0],
                               h: sort_rd_ff.h};
               taken_in[scan_ff[IDX_BITS-1:0]] = 1'b1;
               pvalid_in[sort_rd_ff.idx]       = 1'b1;
               stk_cmd.push        = 1'b1;
               stk_cmd.frame.tail  = bs_end[DIM_BITS-1:0];
               stk_cmd.frame.y     = by_ff;
               stk_cmd.frame.orig  = sort_rd_ff.h;
               stk_cmd.frame.hcur  = sort_rd_ff.h;
               stk_cmd.frame.yoff  = '0;
               stk_cmd.frame.start = scan_ff + CNT_BITS'(1);
               scan_in             = scan_ff + CNT_BITS'(1);
            end
         end
         ST_BS_FAIL: begin
            if (stk_depth == '0) begin
               ty_in = ty_ff + DIM_BITS'(toph_ff);
               ti_in = ti_ff + CNT_BITS'(1);
            end
         end
         ST_FS_RD: begin
            if (!scan_end && scan_taken) scan_in = scan_ff + CNT_BITS'(1);
         end
         ST_FS_EV: begin
            if (!fs_short) begin
               if (fs_fit) begin
                  place_we    = 1'b1;
                  place_wdata = '{x: (ftop.tail[COORD_BITS] ? {COORD_BITS{1'b1}}
                                                            : ftop.tail[COORD_BITS-1:0]),
                                  y: ftop.y[COORD_BITS-1:0],
                                  h: ftop.orig};
                  taken_in[scan_ff[IDX_BITS-1:0]] = 1'b1;
                  pvalid_in[sort_rd_ff.idx]       = 1'b1;
                  if (fs_full) begin
                     stk_cmd.pop = 1'b1;
                  end else begin
                     stk_cmd.upd        = 1'b1;
                     stk_cmd.frame      = ftop;
                     stk_cmd.frame.tail = fs_end[DIM_BITS-1:0];
                     scan_in            = scan_ff + CNT_BITS'(1);
                  end
               end else begin
                  scan_in = scan_ff + CNT_BITS'(1);
               end
            end
         end
         ST_FL_POST: begin
            if (ftop.orig == SIZE_BITS'(1)) stk_cmd.pop = 1'b1;
         end
         ST_FL_HALVE: begin
            if (halve_h == '0) begin
               stk_cmd.pop = 1'b1;
            end else begin
               stk_cmd.upd        = 1'b1;
               stk_cmd.frame      = ftop;
               stk_cmd.frame.hcur = halve_h;
               bx_in   = ftop.tail;
               by_in   = ftop.y + DIM_BITS'(ftop.yoff);
               bh_in   = halve_h;
               scan_in = ftop.start;
            end
         end
         ST_RET_T: begin
            if (stk_depth == '0) begin
               ty_in = ty_ff + DIM_BITS'(toph_ff);
               ti_in = ti_ff + CNT_BITS'(1);
            end else if (ret_over) begin
               stk_cmd.pop = 1'b1;
            end else begin
               // sub-shelf placed, stack another one of the same height
               stk_cmd.upd        = 1'b1;
               stk_cmd.frame      = ftop;
               stk_cmd.frame.yoff = ret_nyoff;
               bx_in   = ftop.tail;
               by_in   = ftop.y + DIM_BITS'(ret_nyoff);
               bh_in   = ftop.hcur;
               scan_in = ftop.start;
            end
         end
         ST_OUT_LD: begin
            rsp_valid_in         = 1'b1;
            rsp_in.rect_index    = oi_ff[IDX_BITS-1:0];
            rsp_in.pos_x         = '0;
            rsp_in.pos_y         = '0;
            rsp_in.padded_height = '0;
            if (pvalid_ff[oi_ff[IDX_BITS-1:0]]) begin
               rsp_in.pos_x         = place_rd_ff.x;
               rsp_in.pos_y         = place_rd_ff.y;
               rsp_in.padded_height = place_rd_ff.h;
            end
            rsp_in.atlas_width  = cw;
            rsp_in.atlas_height = ty_ff;
            rsp_in.overflow     = ovf_ff;
            rsp_in.last_result  = out_last;
         end
         ST_OUT_HOLD: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (out_last) begin
                  cnt_in     = '0;
                  area_in    = '0;
                  widest_in  = '0;
                  dropped_in = 1'b0;
               end else begin
                  oi_in = oi_ff + CNT_BITS'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         area_ff      <= '0;
         widest_ff    <= '0;
         dropped_ff   <= 1'b0;
         wl_ff        <= '0;
         taken_ff     <= '0;
         pvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         area_ff      <= area_in;
         widest_ff    <= widest_in;
         dropped_ff   <= dropped_in;
         wl_ff        <= wl_in;
         taken_ff     <= taken_in;
         pvalid_ff    <= pvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff  <= ovf_in;
      si_ff   <= si_in;
      sj_ff   <= sj_in;
      rank_ff <= rank_in;
      cur_ff  <= cur_in;
      ti_ff   <= ti_in;
      ty_ff   <= ty_in;
      toph_ff <= toph_in;
      scan_ff <= scan_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      bh_ff   <= bh_in;
      oi_ff   <= oi_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[cnt_ff[IDX_BITS-1:0]] <= '{w: req_data.rect_width, h: req_data.rect_height};
      end
      size_rd_ff <= size_mem[size_raddr];
   end

   always_ff @(posedge clock) begin
      if (sort_we) begin
         sort_mem[rank_ff] <= '{idx: si_ff[IDX_BITS-1:0], w: cur_ff.w, h: cur_ff.h};
      end
      sort_rd_ff <= sort_mem[sort_raddr];
   end

   always_ff @(posedge clock) begin
      if (place_we) begin
         place_mem[sort_rd_ff.idx] <= place_wdata;
      end
      place_rd_ff <= place_mem[oi_ff[IDX_BITS-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stk_depth <= DEPTH_BITS'(STACK_DEPTH))
      else $error("frame stack overrun");

   a_top_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TOP_RD) |-> (stk_depth == '0))
      else $error("open fill frame left at shelf start");

   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_OUT_HOLD))
      else $error("result valid outside output hold");

   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(MAX_RECTS))
      else $error("rectangle count beyond store depth");

endmodule
`default_nettype wire
